/* rtl/core/wsr_pkg.sv */
// ----------------------------------------------------------------------------
// wsr_pkg
// Shared types and constants of the waiter stack with removal.
// ----------------------------------------------------------------------------
package wsr_pkg;

    localparam int NUM_WAITERS = 16;
    localparam int ID_W        = (NUM_WAITERS > 2) ? $clog2(NUM_WAITERS) : 1;
    localparam int LINK_W      = $clog2(NUM_WAITERS + 1);
    localparam int STEP_W      = $clog2(NUM_WAITERS + 1);
    localparam int REQ_W       = 2;
    localparam int WID_W       = 4;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_WAITERS);

    typedef logic [ID_W-1:0]   t_id;
    typedef logic [LINK_W-1:0] t_link;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_REMOVE = 2'd2
    } t_req_type;

    typedef struct packed {
        logic  we;
        t_id   waddr;
        t_link wdata;
        t_id   raddr;
    } t_mem_ctl;

endpackage

/* rtl/core/wsr_req_if.sv */
// ----------------------------------------------------------------------------
// wsr_req_if
// Request channel: operation code and waiter id.
// ----------------------------------------------------------------------------
interface wsr_req_if;
    logic                      valid;
    logic                      ready;
    logic [wsr_pkg::REQ_W-1:0] req_type;
    logic [wsr_pkg::WID_W-1:0] waiter_id;

    modport source (output valid, output req_type, output waiter_id, input ready);
    modport sink   (input valid, input req_type, input waiter_id, output ready);
endinterface

/* rtl/core/wsr_rsp_if.sv */
// ----------------------------------------------------------------------------
// wsr_rsp_if
// Response channel: one result word per request.
// ----------------------------------------------------------------------------
interface wsr_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      got_waiter;
    logic [wsr_pkg::WID_W-1:0] waiter_out;
    logic                      was_linked;
    logic                      push_rejected;

    modport source (output valid, output got_waiter, output waiter_out,
                    output was_linked, output push_rejected, input ready);
    modport sink   (input valid, input got_waiter, input waiter_out,
                    input was_linked, input push_rejected, output ready);
endinterface

/* rtl/core/waiter_stack_with_removal.sv */
// ----------------------------------------------------------------------------
// waiter_stack_with_removal
// LIFO list of waiters with push, pop and remove by id.
// ----------------------------------------------------------------------------
// Requests arrive on i_req as a word of req_type and waiter_id; each request
// returns exactly one word on o_rsp. Push, a pop of an empty list, a remove
// of an unlinked waiter and an unknown code finish in the accepting cycle,
// so their result is visible in the next cycle. A pop that finds a waiter
// goes through S_POP_RD and S_DONE, bound by the registered read of the
// next-link memory. A remove walks the list one link per read, through
// S_WALK and S_WALK_RD for each link, then S_CLEAR and S_DONE; the walk
// stops after NUM_WAITERS links. One request is in work at a time.
// Reset empties the list and clears all linked flags; the link memory needs
// no clearing. The result sits in an output register: a new request is taken
// while it waits as long as that word leaves in the same cycle, and a stalled
// receiver holds the block once the result register is full.
// ----------------------------------------------------------------------------
module waiter_stack_with_removal (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsr_req_if.sink    i_req,
    wsr_rsp_if.source  o_rsp
);
    import wsr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_POP_RD  = 6'b000010,
        S_WALK    = 6'b000100,
        S_WALK_RD = 6'b001000,
        S_CLEAR   = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    t_link                 r_head, n_head;
    logic [NUM_WAITERS-1:0] r_flag, n_flag;
    t_id                   r_id, n_id;
    t_link                 r_cur, n_cur;
    t_link                 r_prev, n_prev;
    logic [STEP_W-1:0]     r_steps, n_steps;
    logic                  r_p_got, n_p_got;
    logic                  r_p_wl, n_p_wl;
    logic                  r_ov, n_ov;
    logic                  r_got, n_got;
    logic [WID_W-1:0]      r_wout, n_wout;
    logic                  r_wl, n_wl;
    logic                  r_pr, n_pr;

    t_mem_ctl              mem_ctl;
    t_link                 mem_rdata;
    logic                  slot_free;
    logic                  in_ready;
    logic                  accept;
    t_link                 req_lk;
    logic                  id_ok;
    t_id                   req_ix;

    wsr_link_mem u_link_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .o_rdata (mem_rdata)
    );

    assign slot_free = !r_ov || o_rsp.ready;
    assign in_ready  = (r_state == S_IDLE) && slot_free;
    assign accept    = i_req.valid && in_ready;
    assign req_lk    = LINK_W'(i_req.waiter_id);
    assign id_ok     = req_lk < NULL_LINK;
    assign req_ix    = req_lk[ID_W-1:0];

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_flag  = r_flag;
        n_id    = r_id;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_steps = r_steps;
        n_p_got = r_p_got;
        n_p_wl  = r_p_wl;
        n_ov    = r_ov;
        n_got   = r_got;
        n_wout  = r_wout;
        n_wl    = r_wl;
        n_pr    = r_pr;
        mem_ctl = '0;

        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ov   = 1'b1;
                    n_got  = 1'b0;
                    n_wout = '0;
                    n_wl   = 1'b0;
                    n_pr   = 1'b0;
                    case (i_req.req_type)
                        REQ_PUSH: begin
                            if (!id_ok || r_flag[req_ix]) begin
                                n_pr = 1'b1;
                            end else begin
                                mem_ctl.we     = 1'b1;
                                mem_ctl.waddr  = req_ix;
                                mem_ctl.wdata  = r_head;
                                n_flag[req_ix] = 1'b1;
                                n_head         = req_lk;
                            end
                        end
                        REQ_POP: begin
                            if (r_head >= NULL_LINK) begin
                                n_head = NULL_LINK;
                            end else begin
                                mem_ctl.raddr = r_head[ID_W-1:0];
                                n_cur         = r_head;
                                n_ov          = r_ov && !o_rsp.ready;
                                n_state       = S_POP_RD;
                            end
                        end
                        REQ_REMOVE: begin
                            if (id_ok && r_flag[req_ix]) begin
                                n_id    = req_ix;
                                n_cur   = r_head;
                                n_prev  = NULL_LINK;
                                n_steps = '0;
                                n_ov    = r_ov && !o_rsp.ready;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                n_head                    = mem_rdata;
                mem_ctl.we                = 1'b1;
                mem_ctl.waddr             = r_cur[ID_W-1:0];
                mem_ctl.wdata             = NULL_LINK;
                n_flag[r_cur[ID_W-1:0]]   = 1'b0;
                n_p_got                   = 1'b1;
                n_p_wl                    = 1'b0;
                n_state                   = S_DONE;
            end
            S_WALK: begin
                if (r_cur >= NULL_LINK || r_steps == STEP_W'(NUM_WAITERS)) begin
                    n_state = S_CLEAR;
                end else begin
                    mem_ctl.raddr = r_cur[ID_W-1:0];
                    n_state       = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (r_cur == LINK_W'(r_id)) begin
                    if (r_prev >= NULL_LINK) begin
                        n_head = mem_rdata;
                    end else begin
                        mem_ctl.we    = 1'b1;
                        mem_ctl.waddr = r_prev[ID_W-1:0];
                        mem_ctl.wdata = mem_rdata;
                    end
                    n_state = S_CLEAR;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = mem_rdata;
                    n_steps = r_steps + 1'b1;
                    n_state = S_WALK;
                end
            end
            S_CLEAR: begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = r_id;
                mem_ctl.wdata = NULL_LINK;
                n_flag[r_id]  = 1'b0;
                n_p_got       = 1'b0;
                n_p_wl        = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_got   = r_p_got;
                    n_wout  = r_p_got ? WID_W'(r_cur) : '0;
                    n_wl    = r_p_wl;
                    n_pr    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NULL_LINK;
            r_flag  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_flag  <= n_flag;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_steps <= n_steps;
        r_p_got <= n_p_got;
        r_p_wl  <= n_p_wl;
        r_got   <= n_got;
        r_wout  <= n_wout;
        r_wl    <= n_wl;
        r_pr    <= n_pr;
    end

    assign i_req.ready         = in_ready;
    assign o_rsp.valid         = r_ov;
    assign o_rsp.got_waiter    = r_got;
    assign o_rsp.waiter_out    = r_wout;
    assign o_rsp.was_linked    = r_wl;
    assign o_rsp.push_rejected = r_pr;

endmodule

/* rtl/core/wsr_link_mem.sv */
// ----------------------------------------------------------------------------
// wsr_link_mem
// Next-link memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wsr_link_mem (
    input  logic               i_clk,
    input  wsr_pkg::t_mem_ctl  i_ctl,
    output wsr_pkg::t_link     o_rdata
);
    import wsr_pkg::*;

    t_link r_mem [NUM_WAITERS];
    t_link r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rdata <= r_mem[i_ctl.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
